/* design/encoder_counter_seven_seg_mux_defines.svh */
// Assertion macros shared by the encoder counter RTL.
// Expects clk and rst_n in scope at the point of use; no other dependencies.
`ifndef ENCODER_COUNTER_SEVEN_SEG_MUX_DEFINES_SVH
`define ENCODER_COUNTER_SEVEN_SEG_MUX_DEFINES_SVH

`ifndef SYNTH
`define ECSSM_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ecssm assertion failed");
`define ECSSM_NEVER(label, expr) \
    `ECSSM_ASSERT(label, !(expr))
`else
`define ECSSM_ASSERT(label, prop)
`define ECSSM_NEVER(label, expr)
`endif

`endif

/* design/ecssm_pkg.sv */
// Shared types, constants and lookup tables for the encoder counter display.
// No dependencies.
package ecssm_pkg;

    typedef enum logic [1:0] {
        FUNC_STEP  = 2'd0,
        FUNC_PRESS = 2'd1,
        FUNC_TICK  = 2'd2
    } func_t;

    localparam int unsigned COUNT_W = 7;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned SEG_W   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX_RESET = 7'd99;
    localparam logic [POS_W-1:0]   SNAKE_LAST      = 4'd11;
    localparam logic [SEG_W-1:0]   SEG_ALL         = 7'h7F;

    // Reciprocal of ten, exact for every 7-bit value.
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int unsigned DIV10_SHIFT = 11;
    localparam int unsigned PROD_W      = COUNT_W + 8;

    function automatic logic [SEG_W-1:0] digit_font(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] seg;
        case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [SEG_W-1:0] snake_seg(input logic [POS_W-1:0] p);
        logic [SEG_W-1:0] seg;
        case (p)
            4'd0, 4'd1:   seg = 7'h01;
            4'd2, 4'd6:   seg = 7'h20;
            4'd3, 4'd5:   seg = 7'h10;
            4'd4, 4'd9:   seg = 7'h08;
            4'd7, 4'd11:  seg = 7'h02;
            4'd8, 4'd10:  seg = 7'h04;
            default:      seg = 7'h00;
        endcase
        return seg;
    endfunction

    function automatic logic snake_on_tens(input logic [POS_W-1:0] p);
        logic on_tens;
        case (p)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd7, 4'd8: on_tens = 1'b1;
            default:                            on_tens = 1'b0;
        endcase
        return on_tens;
    endfunction

endpackage

/* design/encoder_counter_seven_seg_mux.sv */
// Encoder counter with a two-digit multiplexed seven-segment display, top level.
// Depends on ecssm_pkg, ecssm_digit_split and the assertion macro header.
//
//   channel | direction | handshake             | word
//   in      | to block  | in_valid / in_ready   | func, dt_level
//   out     | from block| out_valid / out_ready | segments, selects, count, position, mode
//   cfg     | to block  | cfg_valid / cfg_ready | cfg_data (count_max)
//
// One word per cycle while in_ready is high: the event updates state in the cycle it is
// accepted and its result word is loaded into the output register at the same clock edge.
// in_ready drops only while the output register is full and out_ready is low.
// cfg_ready is always high. Reset brings count_max to 99, all segments lit,
// tens select low and units select high, number mode.
`include "encoder_counter_seven_seg_mux_defines.svh"

module encoder_counter_seven_seg_mux (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic                          dt_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ecssm_pkg::SEG_W-1:0]   segments,
    output logic                          tens_select_n,
    output logic                          units_select_n,
    output logic [ecssm_pkg::COUNT_W-1:0] count_value,
    output logic [ecssm_pkg::POS_W-1:0]   snake_position,
    output logic                          snake_mode,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ecssm_pkg::COUNT_W-1:0] cfg_data
);
    import ecssm_pkg::*;

    logic [COUNT_W-1:0] count_max_reg;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [POS_W-1:0]   snake_pos_reg, snake_pos_next;
    logic               mode_reg,      mode_next;
    logic [SEG_W-1:0]   segment_reg,   segment_next;
    logic               tens_sel_reg,  tens_sel_next;
    logic               units_sel_reg, units_sel_next;

    logic               out_valid_reg, out_valid_next;
    logic [SEG_W-1:0]   out_seg_reg;
    logic               out_tens_reg;
    logic               out_units_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_mode_reg;

    logic               in_fire;
    logic [DIGIT_W-1:0] tens_digit;
    logic [DIGIT_W-1:0] units_digit;

    ecssm_digit_split u_digit_split (
        .value (count_reg),
        .tens  (tens_digit),
        .units (units_digit)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        count_next     = count_reg;
        snake_pos_next = snake_pos_reg;
        mode_next      = mode_reg;
        segment_next   = segment_reg;
        tens_sel_next  = tens_sel_reg;
        units_sel_next = units_sel_reg;
        case (func_t'(func))
            FUNC_STEP:
            begin
                if (!mode_reg)
                begin
                    if (dt_level)
                    begin
                        if (count_reg < count_max_reg)
                            count_next = count_reg + 1'b1;
                    end
                    else if (count_reg != '0)
                        count_next = count_reg - 1'b1;
                end
                else if (dt_level)
                    snake_pos_next = (snake_pos_reg >= SNAKE_LAST) ? '0
                                                                   : snake_pos_reg + 1'b1;
                else
                    snake_pos_next = (snake_pos_reg == '0 || snake_pos_reg > SNAKE_LAST)
                                     ? SNAKE_LAST : snake_pos_reg - 1'b1;
            end
            FUNC_PRESS:
                mode_next = !mode_reg;
            FUNC_TICK:
            begin
                if (!mode_reg)
                begin
                    if (tens_sel_reg || units_sel_reg)
                    begin
                        segment_next   = digit_font(tens_sel_reg ? tens_digit : units_digit);
                        tens_sel_next  = !tens_sel_reg;
                        units_sel_next = !units_sel_reg;
                    end
                end
                else if (snake_pos_reg <= SNAKE_LAST)
                begin
                    segment_next   = snake_seg(snake_pos_reg);
                    tens_sel_next  = !snake_on_tens(snake_pos_reg);
                    units_sel_next = snake_on_tens(snake_pos_reg);
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_max_reg <= COUNT_MAX_RESET;
            count_reg     <= '0;
            snake_pos_reg <= '0;
            mode_reg      <= 1'b0;
            segment_reg   <= SEG_ALL;
            tens_sel_reg  <= 1'b0;
            units_sel_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                count_max_reg <= cfg_data;
            if (in_fire)
            begin
                count_reg     <= count_next;
                snake_pos_reg <= snake_pos_next;
                mode_reg      <= mode_next;
                segment_reg   <= segment_next;
                tens_sel_reg  <= tens_sel_next;
                units_sel_reg <= units_sel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_seg_reg   <= segment_next;
            out_tens_reg  <= tens_sel_next;
            out_units_reg <= units_sel_next;
            out_count_reg <= count_next;
            out_pos_reg   <= snake_pos_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign segments       = out_seg_reg;
    assign tens_select_n  = out_tens_reg;
    assign units_select_n = out_units_reg;
    assign count_value    = out_count_reg;
    assign snake_position = out_pos_reg;
    assign snake_mode     = out_mode_reg;

    `ECSSM_NEVER(a_pos_in_range, snake_pos_reg > SNAKE_LAST)
    `ECSSM_NEVER(a_selects_differ, tens_sel_reg == units_sel_reg)
    `ECSSM_ASSERT(a_fire_gives_word, in_fire |=> out_valid)
    `ECSSM_ASSERT(a_press_toggles,
        in_fire && func == FUNC_PRESS |=> mode_reg != $past(mode_reg))
    `ECSSM_ASSERT(a_up_step,
        in_fire && func == FUNC_STEP && !mode_reg && dt_level && count_reg < count_max_reg
        |=> count_reg == $past(count_reg) + 1'b1)

endmodule

/* design/ecssm_digit_split.sv */
// Splits the count into its tens and units digits by reciprocal multiply.
// Depends on ecssm_pkg.
module ecssm_digit_split (
    input  logic [ecssm_pkg::COUNT_W-1:0] value,
    output logic [ecssm_pkg::DIGIT_W-1:0] tens,
    output logic [ecssm_pkg::DIGIT_W-1:0] units
);
    import ecssm_pkg::*;

    logic [PROD_W-1:0]  prod;
    logic [COUNT_W-1:0] tens_x10;
    logic [COUNT_W-1:0] rem;

    assign prod     = PROD_W'(value) * PROD_W'(DIV10_MUL);
    assign tens     = prod[DIV10_SHIFT +: DIGIT_W];
    assign tens_x10 = COUNT_W'({tens, 3'b000}) + COUNT_W'({tens, 1'b0});
    assign rem      = value - tens_x10;
    assign units    = rem[DIGIT_W-1:0];

endmodule
